[design/cle_pkg.sv]
// cle_pkg: shared constants, codes and types for the console line editor.
// No dependencies; every other file but cle_ram imports it.
package cle_pkg;

   // Line geometry: the store keeps LINE_LENGTH-1 characters.
   localparam int LINE_LENGTH = 64;
   localparam int STORE_DEPTH = LINE_LENGTH - 1;
   localparam int CURSOR_W    = $clog2(LINE_LENGTH);
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Field widths.
   localparam int RX_W       = 8;
   localparam int CHAR_W     = 7;
   localparam int KIND_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   // Command queue between front and back.
   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int CMD_QUEUE_AW    = $clog2(CMD_QUEUE_DEPTH);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_ENABLE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_DELIVERY = 1'd1;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_ECHO    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BELL    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NEWLINE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LINE    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd4;

   // Received byte codes.
   localparam logic [RX_W-1:0] RX_BS       = 8'd8;
   localparam logic [RX_W-1:0] RX_LF       = 8'd10;
   localparam logic [RX_W-1:0] RX_CR       = 8'd13;
   localparam logic [RX_W-1:0] RX_DEL      = 8'd127;
   localparam logic [RX_W-1:0] RX_PRINT_LO = 8'h20;
   localparam logic [RX_W-1:0] RX_PRINT_HI = 8'h7E;

   // Echoed characters of the erase sequence, and the empty byte of other results.
   localparam logic [CHAR_W-1:0] CH_BS    = 7'd8;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
   localparam logic [CHAR_W-1:0] CH_NONE  = 7'd0;

   typedef enum logic [1:0] {
      CMD_ECHO,
      CMD_BELL,
      CMD_ERASE,
      CMD_ENTER
   } cmd_op_type;

   // One queued command: what the back end has to emit.
   typedef struct packed {
      cmd_op_type          op;
      logic [CHAR_W-1:0]   ch;
      logic                deliver;
      logic [CURSOR_W-1:0] len;
   } cmd_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ERASE_SP,
      B_ERASE_BS,
      B_EMPTY,
      B_LINE_WAIT,
      B_LINE
   } back_state_type;

endpackage

[design/cle_ram.sv]
// cle_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                           clock,
   input  logic                                           we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
   input  logic [WIDTH-1:0]                               wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
   output logic [WIDTH-1:0]                               rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/cle_cmd_fifo.sv]
// cle_cmd_fifo: short show-ahead command queue between front and back end.
// Depends on cle_pkg.
module cle_cmd_fifo import cle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type                 entry_ff [CMD_QUEUE_DEPTH];
   logic [CMD_QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_QUEUE_AW:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == (CMD_QUEUE_AW+1)'(CMD_QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMD_QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + CMD_QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (CMD_QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (CMD_QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/cle_front.sv]
// cle_front: accepts received bytes, classifies them, edits cursor and line
// store, and queues commands for the back end. Depends on cle_pkg.
module cle_front import cle_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [RX_W-1:0]           req_rx_byte,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data,
   output logic                      cmd_push,
   output cmd_type                   cmd_data,
   input  logic                      cmd_full,
   input  logic                      line_done,
   output logic                      ram_we,
   output logic [STORE_AW-1:0]       ram_waddr,
   output logic [CHAR_W-1:0]         ram_wdata
);

   logic                echo_ff, echo_in;
   logic                deliver_ff, deliver_in;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic                line_busy_ff, line_busy_in;
   logic                accept, is_enter, is_print, is_erase, store_full;

   assign is_enter   = (req_rx_byte == RX_LF) || (req_rx_byte == RX_CR);
   assign is_print   = (req_rx_byte >= RX_PRINT_LO) && (req_rx_byte <= RX_PRINT_HI);
   assign is_erase   = (req_rx_byte == RX_DEL) || (req_rx_byte == RX_BS);
   assign store_full = (cursor_ff == CURSOR_W'(STORE_DEPTH));

   // Hold off input while the command queue is full or a line is being read out of the store.
   assign req_stall = cmd_full | line_busy_ff;
   assign accept    = req_valid & ~req_stall;

   assign ram_waddr = cursor_ff[STORE_AW-1:0];
   assign ram_wdata = req_rx_byte[CHAR_W-1:0];

   always_comb begin
      echo_in    = echo_ff;
      deliver_in = deliver_ff;
      if (csr_write_enable) begin
         if (csr_index == CSR_ECHO_ENABLE) begin
            echo_in = csr_write_data[0];
         end
         if (csr_index == CSR_LINE_DELIVERY) begin
            deliver_in = csr_write_data[0];
         end
      end
   end

   always_comb begin
      cursor_in        = cursor_ff;
      line_busy_in     = line_busy_ff & ~line_done;
      cmd_push         = 1'b0;
      ram_we           = 1'b0;
      cmd_data.op      = CMD_ECHO;
      cmd_data.ch      = req_rx_byte[CHAR_W-1:0];
      cmd_data.deliver = deliver_ff;
      cmd_data.len     = cursor_ff;
      priority if (accept && is_enter) begin
         cmd_push    = 1'b1;
         cmd_data.op = CMD_ENTER;
         cursor_in   = '0;
         if (deliver_ff && (cursor_ff != '0)) begin
            line_busy_in = 1'b1;
         end
      end else if (accept && is_print && store_full) begin
         cmd_push    = 1'b1;
         cmd_data.op = CMD_BELL;
      end else if (accept && is_print) begin
         ram_we      = 1'b1;
         cursor_in   = cursor_ff + CURSOR_W'(1);
         cmd_push    = echo_ff;
         cmd_data.op = CMD_ECHO;
      end else if (accept && is_erase && (cursor_ff != '0)) begin
         cursor_in   = cursor_ff - CURSOR_W'(1);
         cmd_push    = echo_ff;
         cmd_data.op = CMD_ERASE;
      end else begin
         cmd_push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_ff      <= 1'b1;
         deliver_ff   <= 1'b0;
         cursor_ff    <= '0;
         line_busy_ff <= 1'b0;
      end else begin
         echo_ff      <= echo_in;
         deliver_ff   <= deliver_in;
         cursor_ff    <= cursor_in;
         line_busy_ff <= line_busy_in;
      end
   end

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      line_busy_ff |-> req_stall)
      else $error("input taken during line readout");

   a_enter_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && is_enter) |=> (cursor_ff == '0))
      else $error("cursor not cleared by enter");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CURSOR_W'(STORE_DEPTH))
      else $error("cursor beyond store");

endmodule

[design/cle_back.sv]
// cle_back: pops queued commands and emits result transactions through an
// output register; reads the line store for delivery. Depends on cle_pkg.
module cle_back import cle_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd_head,
   input  logic                  cmd_empty,
   output logic                  cmd_pop,
   output logic [STORE_AW-1:0]   ram_raddr,
   input  logic [CHAR_W-1:0]     ram_rdata,
   output logic                  line_done,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [CHAR_W-1:0]     rsp_out_byte,
   output logic                  rsp_last
);

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CURSOR_W-1:0] idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [CHAR_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                out_free, load, line_last;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign line_last = (idx_ff == (cmd_ff.len - CURSOR_W'(1)));
   assign ram_raddr = idx_ff[STORE_AW-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_empty && out_free) begin
               unique case (cmd_head.op)
                  CMD_ERASE: state_in = B_ERASE_SP;
                  CMD_ENTER: begin
                     if (cmd_head.deliver) begin
                        state_in = (cmd_head.len == '0) ? B_EMPTY : B_LINE_WAIT;
                     end
                  end
                  default:   state_in = B_IDLE;
               endcase
            end
         end
         B_ERASE_SP:  state_in = out_free ? B_ERASE_BS : B_ERASE_SP;
         B_ERASE_BS:  state_in = out_free ? B_IDLE : B_ERASE_BS;
         B_EMPTY:     state_in = out_free ? B_IDLE : B_EMPTY;
         B_LINE_WAIT: state_in = B_LINE;
         B_LINE: begin
            if (out_free) begin
               state_in = line_last ? B_IDLE : B_LINE_WAIT;
            end
         end
         default:     state_in = B_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      cmd_pop     = 1'b0;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      load        = 1'b0;
      line_done   = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_empty && out_free) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_head;
               idx_in  = '0;
               load    = 1'b1;
               unique case (cmd_head.op)
                  CMD_ECHO: begin
                     rsp_kind_in = KIND_ECHO;
                     rsp_byte_in = cmd_head.ch;
                     rsp_last_in = 1'b1;
                  end
                  CMD_BELL: begin
                     rsp_kind_in = KIND_BELL;
                     rsp_byte_in = CH_NONE;
                     rsp_last_in = 1'b1;
                  end
                  CMD_ERASE: begin
                     rsp_kind_in = KIND_ECHO;
                     rsp_byte_in = CH_BS;
                     rsp_last_in = 1'b0;
                  end
                  CMD_ENTER: begin
                     rsp_kind_in = KIND_NEWLINE;
                     rsp_byte_in = CH_NONE;
                     rsp_last_in = ~cmd_head.deliver;
                  end
                  default: begin
                     load = 1'b0;
                  end
               endcase
            end
         end
         B_ERASE_SP: begin
            load        = out_free;
            rsp_kind_in = KIND_ECHO;
            rsp_byte_in = CH_SPACE;
            rsp_last_in = 1'b0;
         end
         B_ERASE_BS: begin
            load        = out_free;
            rsp_kind_in = KIND_ECHO;
            rsp_byte_in = CH_BS;
            rsp_last_in = 1'b1;
         end
         B_EMPTY: begin
            load        = out_free;
            rsp_kind_in = KIND_EMPTY;
            rsp_byte_in = CH_NONE;
            rsp_last_in = 1'b1;
         end
         B_LINE_WAIT: begin
            load = 1'b0;
         end
         B_LINE: begin
            load        = out_free;
            rsp_kind_in = KIND_LINE;
            rsp_byte_in = ram_rdata;
            rsp_last_in = line_last;
            if (out_free) begin
               idx_in    = idx_ff + CURSOR_W'(1);
               line_done = line_last;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   a_wait_then_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_LINE_WAIT) |=> (state_ff == B_LINE))
      else $error("read wait not followed by line byte");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      line_done |=> (rsp_valid_ff && rsp_last_ff && (rsp_kind_ff == KIND_LINE)))
      else $error("line end without last line byte");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> ((state_ff == B_IDLE) && !cmd_empty && load))
      else $error("command popped outside idle");

endmodule

[design/console_line_editor.sv]
// console_line_editor: top level of the serial console line editor.
// Depends on cle_pkg, cle_front, cle_cmd_fifo, cle_back and cle_ram.
//
// Takes one received byte per req_ transaction and edits a line of up to
// LINE_LENGTH-1 (63) characters. Printable bytes 0x20..0x7E are stored and,
// with echo_enable set, echoed; a full line answers with a bell. Backspace
// (8) and delete (127) drop the last character and, with echo_enable set,
// echo BS, space, BS. LF or CR emit a newline marker and, with
// line_delivery_enable set, the stored line one byte per rsp_ transaction
// (or one empty-line item), then clear the line. Every input that produces
// results marks its final result with rsp_last; ignored bytes produce
// nothing. Timing: the front end takes a byte whenever its 4-entry command
// queue has room and no line readout is under way, so typing runs at one
// byte per clock while the output side keeps up. Each result leaves through
// the output register at one per clock while rsp_stall is low, except line
// bytes, which each pass through B_LINE_WAIT for the registered read of the
// line store RAM. After an enter with a non-empty line and delivery on,
// req_stall stays high until the last line byte has been loaded, also
// waiting out any rsp_ stall and any commands queued ahead of the enter.
// Configuration writes through csr_ take effect on the next clock and are
// expected while the block is idle. No clearing pass is needed after reset.
module console_line_editor import cle_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Received byte channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [RX_W-1:0]       req_rx_byte,
   // Result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [CHAR_W-1:0]     rsp_out_byte,
   output logic                  rsp_last,
   // Register write port
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type             cmd_push_data, cmd_head;
   logic                cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic                line_done;
   logic                ram_we;
   logic [STORE_AW-1:0] ram_waddr, ram_raddr;
   logic [CHAR_W-1:0]   ram_wdata, ram_rdata;

   // Front end: classification, cursor and store writes.
   cle_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_push_data),
      .cmd_full         (cmd_full),
      .line_done        (line_done),
      .ram_we           (ram_we),
      .ram_waddr        (ram_waddr),
      .ram_wdata        (ram_wdata)
   );

   // Command queue decoupling the two halves.
   cle_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty)
   );

   // Line store; written by the front end, read during line readout.
   cle_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Back end: expands commands into result transactions.
   cle_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_head     (cmd_head),
      .cmd_empty    (cmd_empty),
      .cmd_pop      (cmd_pop),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata),
      .line_done    (line_done),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

[tb/cle_checker.sv]
`timescale 1ns / 1ps
// cle_checker: watches the req_, rsp_ and csr_ ports of the console line editor,
// predicts every result from the accepted bytes and compares in order.
// Depends on cle_pkg for widths, result kinds, byte codes and register indexes.
module cle_checker import cle_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [RX_W-1:0]       req_rx_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [KIND_W-1:0]     rsp_kind,
   input  logic [CHAR_W-1:0]     rsp_out_byte,
   input  logic                  rsp_last,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    fail_count,
   output int                    expected_left
);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] ch;
      logic              last;
   } editor_result_type;

   editor_result_type editor_results_q[$];
   editor_result_type want;
   logic [CHAR_W-1:0] line_chars [STORE_DEPTH];
   logic [CURSOR_W-1:0] line_len;
   logic              echo_on;
   logic              deliver_on;
   int                mismatches = 0;
   int                results_waiting = 0;

   assign fail_count    = mismatches;
   assign expected_left = results_waiting;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   function automatic editor_result_type make_result(input logic [KIND_W-1:0] kind,
                                                     input logic [CHAR_W-1:0] ch);
      editor_result_type r;
      r.kind = kind;
      r.ch   = ch;
      r.last = 1'b0;
      return r;
   endfunction

   // Line editing for one received byte; the final result gets the last flag.
   task automatic edit_line(input logic [RX_W-1:0] rx);
      editor_result_type batch[$];
      editor_result_type r;
      int i;
      if (rx == RX_LF || rx == RX_CR) begin
         batch.push_back(make_result(KIND_NEWLINE, CH_NONE));
         if (deliver_on) begin
            if (line_len == 0)
               batch.push_back(make_result(KIND_EMPTY, CH_NONE));
            for (i = 0; i < int'(line_len); i++)
               batch.push_back(make_result(KIND_LINE, line_chars[i]));
         end
         line_len = '0;
      end else if (rx >= RX_PRINT_LO && rx <= RX_PRINT_HI) begin
         if (int'(line_len) < STORE_DEPTH) begin
            line_chars[line_len] = rx[CHAR_W-1:0];
            line_len = line_len + CURSOR_W'(1);
            if (echo_on)
               batch.push_back(make_result(KIND_ECHO, rx[CHAR_W-1:0]));
         end else begin
            batch.push_back(make_result(KIND_BELL, CH_NONE));
         end
      end else if (rx == RX_DEL || rx == RX_BS) begin
         if (line_len != 0) begin
            line_len = line_len - CURSOR_W'(1);
            if (echo_on) begin
               batch.push_back(make_result(KIND_ECHO, CH_BS));
               batch.push_back(make_result(KIND_ECHO, CH_SPACE));
               batch.push_back(make_result(KIND_ECHO, CH_BS));
            end
         end
      end
      for (i = 0; i < batch.size(); i++) begin
         r = batch[i];
         r.last = (i == batch.size() - 1);
         editor_results_q.push_back(r);
      end
   endtask

   // Results first: a result can never come from a byte taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         editor_results_q.delete();
         line_len   = '0;
         echo_on    = 1'b1;
         deliver_on = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (editor_results_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d byte %0d last %0d",
                                         rsp_kind, rsp_out_byte, rsp_last));
            end else begin
               want = editor_results_q.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch($sformatf("kind expected %0d got %0d",
                                            want.kind, rsp_kind));
               if (rsp_out_byte !== want.ch)
                  report_mismatch($sformatf("out_byte expected %0d got %0d",
                                            want.ch, rsp_out_byte));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last expected %0d got %0d",
                                            want.last, rsp_last));
            end
         end
         if (req_valid && !req_stall)
            edit_line(req_rx_byte);
         if (csr_write_enable) begin
            if (csr_index == CSR_ECHO_ENABLE)
               echo_on = csr_write_data[0];
            else if (csr_index == CSR_LINE_DELIVERY)
               deliver_on = csr_write_data[0];
         end
      end
      results_waiting = editor_results_q.size();
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for the console line editor.
// Depends on cle_pkg, console_line_editor and cle_checker.
module tb_top;
   import cle_pkg::*;

   localparam int HOLD_CYCLES    = 200;  // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 3000; // cycles with no transaction at all
   localparam int SETTLE_CYCLES  = 16;   // lets silent bytes drain before a write
   localparam int PHASE_ITEMS    = 45;
   localparam int NUM_PHASES     = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [RX_W-1:0]       req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [KIND_W-1:0]     rsp_kind;
   logic [CHAR_W-1:0]     rsp_out_byte;
   logic                  rsp_last;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int fail_count;
   int expected_left;

   // Traffic shaping read by the sender task and the receiver process, and the watchdog and item counters.
   int send_gap_pct  = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;
   int items_typed   = 0;

   console_line_editor dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   cle_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .expected_left    (expected_left)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Receiver: random stall, or a long hold-off when the stimulus asks for one.
   // The hold-off lets the command queue fill so req_stall has to rise.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: any transaction on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Called right after a falling edge; returns right after the falling edge
   // that follows acceptance, so back-to-back bytes keep req_valid high.
   task automatic send_rx(input logic [RX_W-1:0] rx);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   task automatic set_traffic(input int gap_pct, input int stall);
      send_gap_pct = gap_pct;
      stall_pct    = stall;
   endtask

   // Registers only change with nothing in flight: drain, settle, then write.
   task automatic write_settings(input logic echo, input logic deliver);
      req_valid <= 1'b0;
      while (expected_left != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ECHO_ENABLE;
      csr_write_data   <= echo;
      @(negedge clock);
      csr_index        <= CSR_LINE_DELIVERY;
      csr_write_data   <= deliver;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // One typed line: mostly printable, some erases, a little noise, then enter.
   // Long lines can run past the 63-character store to provoke bells.
   task automatic type_random_line(input bit force_long);
      int len;
      int k;
      int pick;
      logic [RX_W-1:0] rx;
      if (force_long || $urandom_range(9) == 0)
         len = $urandom_range(70, 55);
      else
         len = $urandom_range(12);
      for (k = 0; k < len; k++) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            rx = RX_W'($urandom_range(RX_PRINT_HI, RX_PRINT_LO));
            items_typed++;
         end else if (pick < 88) begin
            rx = $urandom_range(1) ? RX_BS : RX_DEL;
            items_typed++;
         end else begin
            rx = RX_W'($urandom_range(255));
         end
         send_rx(rx);
      end
      send_rx($urandom_range(1) ? RX_CR : RX_LF);
      items_typed++;
   endtask

   initial begin
      int ph;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_rx_byte      = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_ECHO_ENABLE;
      csr_write_data   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset settings give echo on, delivery off.
      set_traffic(0, 0);
      send_rx(RX_CR);                 // newline marker only
      write_settings(1'b1, 1'b1);
      send_rx(RX_LF);                 // empty line delivered
      send_rx(8'h20);                 // lowest printable
      send_rx(8'h7E);                 // highest printable
      send_rx(8'h41);
      send_rx(RX_DEL);                // erase sequences
      send_rx(RX_BS);
      send_rx(8'h1F);                 // ignored control and high bytes
      send_rx(8'h80);
      send_rx(8'hFF);
      send_rx(8'h00);
      send_rx(8'h09);
      send_rx(RX_CR);                 // one-character line delivered
      send_rx(RX_BS);                 // erase on empty line is ignored
      send_rx(RX_DEL);
      write_settings(1'b0, 1'b1);     // echo off: silent store and erase
      send_rx(8'h78);
      send_rx(RX_BS);
      send_rx(8'h79);
      send_rx(RX_CR);

      // Random: every setting combination and every traffic pattern, two rounds.
      // The first phase holds off the receiver and types a long line that can fill the store to the bell.
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         write_settings(!ph[0], !ph[1]);
         case (ph % 4)
            0: set_traffic(0, 0);
            1: set_traffic(57, 0);
            2: set_traffic(0, 57);
            default: set_traffic(15, 15);
         endcase
         if (ph == 0)
            hold_requests++;
         items_typed = 0;
         type_random_line(ph == 0);
         while (items_typed < PHASE_ITEMS)
            type_random_line(1'b0);
      end

      req_valid <= 1'b0;
      while (expected_left != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[sim.f]
design/cle_pkg.sv
design/cle_ram.sv
design/cle_cmd_fifo.sv
design/cle_front.sv
design/cle_back.sv
design/console_line_editor.sv
tb/cle_checker.sv
tb/tb_top.sv
